[rtl/tld_pkg.sv]
// ============================================================================
// tld_pkg
// Shared types, codes and constants of the terminal line discipline core.
// ============================================================================
package tld_pkg;

    localparam int LINE_DEPTH_DEF = 32;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_group;
    typedef logic [5:0]  t_mode;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_MODE    = 3'd0,
        REG_INTR    = 3'd1,
        REG_QUIT    = 3'd2,
        REG_ERASE   = 3'd3,
        REG_KILL    = 3'd4,
        REG_EOF     = 3'd5,
        REG_SUSPEND = 3'd6,
        REG_FG      = 3'd7
    } t_reg_idx;

    // Mode flag bit positions
    localparam int MODE_ENABLE = 0;
    localparam int MODE_ECHO   = 1;
    localparam int MODE_CANON  = 2;
    localparam int MODE_SIG    = 3;
    localparam int MODE_ONLCR  = 4;
    localparam int MODE_ICRNL  = 5;

    // Reset values of the registers
    localparam t_mode  MODE_RST    = 6'h3F;
    localparam t_byte  INTR_RST    = 8'h03;
    localparam t_byte  QUIT_RST    = 8'h1C;
    localparam t_byte  ERASE_RST   = 8'h7F;
    localparam t_byte  KILL_RST    = 8'h15;
    localparam t_byte  EOF_RST     = 8'h04;
    localparam t_byte  SUSPEND_RST = 8'h1A;
    localparam t_group FG_RST      = 16'h0001;

    // Fixed characters
    localparam t_byte CH_BS       = 8'h08;
    localparam t_byte CH_SP       = 8'h20;
    localparam t_byte CH_CR       = 8'h0D;
    localparam t_byte CH_LF       = 8'h0A;
    localparam t_byte CH_EOF_MARK = 8'hFF;

    // Signal codes carried in the data byte
    localparam t_byte SIG_INTR    = 8'd0;
    localparam t_byte SIG_QUIT    = 8'd1;
    localparam t_byte SIG_SUSPEND = 8'd2;

    typedef enum logic [1:0] {
        DEST_ECHO = 2'd0,
        DEST_READ = 2'd1,
        DEST_SIG  = 2'd2
    } t_dest;

    // Class of the character being handled
    typedef enum logic [3:0] {
        K_OFF,
        K_INTR,
        K_QUIT,
        K_SUSP,
        K_RAW,
        K_ERASE,
        K_KILL,
        K_EOF,
        K_NORMAL
    } t_kind;

    // Source of the byte of an emitted result
    typedef enum logic [2:0] {
        SEL_SIG,
        SEL_CHAR,
        SEL_FF,
        SEL_BS,
        SEL_SP,
        SEL_CR,
        SEL_LF,
        SEL_STORE
    } t_sel;

    typedef struct packed {
        logic  latch;
        logic  push;
        logic  erase;
        logic  kill;
        logic  pop;
        logic  emit;
        t_dest dest;
        t_sel  sel;
        logic  last;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  echo;
        logic  onlcr;
        logic  is_lf;
        logic  empty;
        logic  full;
        logic  pop_last;
        logic  out_free;
    } t_status;

endpackage

[rtl/tld_if.sv]
// ============================================================================
// tld_if
// Valid/ready channels of the line discipline: characters in, results out,
// and configuration writes.
// ============================================================================
interface tld_char_if;
    logic           valid;
    logic           ready;
    tld_pkg::t_byte char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface tld_res_if;
    logic            valid;
    logic            ready;
    logic [1:0]      destination;
    tld_pkg::t_byte  data_byte;
    tld_pkg::t_group target_group;
    logic            last;

    modport source (output valid, output destination, output data_byte,
                    output target_group, output last, input ready);
    modport sink   (input valid, input destination, input data_byte,
                    input target_group, input last, output ready);
endinterface

interface tld_cfg_if;
    logic            valid;
    logic            ready;
    logic [2:0]      index;
    tld_pkg::t_group data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/tld_datapath.sv]
// ============================================================================
// tld_datapath
// Configuration registers, character decode, line store with its ring
// pointers, and the result output register.
// ============================================================================
module tld_datapath #(
    parameter int LINE_DEPTH = tld_pkg::LINE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tld_cfg_if.sink           i_cfg,
    input  tld_pkg::t_byte    i_char,
    tld_res_if.source         o_res,
    input  tld_pkg::t_cmd     i_cmd,
    output tld_pkg::t_status  o_status
);
    import tld_pkg::*;

    localparam int PTR_W = $clog2(LINE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(LINE_DEPTH - 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_POS) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? LAST_POS : p - 1'b1;
    endfunction

    t_mode  r_mode;
    t_byte  r_intr, r_quit, r_erase, r_kill, r_eof, r_susp;
    t_group r_fg;

    t_byte  r_char;
    t_kind  kind;

    logic [PTR_W-1:0] r_rd_pos, r_wr_pos, n_rd_pos, n_wr_pos;
    t_byte  r_line_store [LINE_DEPTH];
    t_byte  r_rd_data;

    logic   r_out_valid;
    t_dest  r_out_dest;
    t_byte  r_out_byte;
    t_group r_out_group;
    logic   r_out_last;
    t_byte  emit_byte;

    // Configuration writes; the port is held off only during reset
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_RST;
            r_intr  <= INTR_RST;
            r_quit  <= QUIT_RST;
            r_erase <= ERASE_RST;
            r_kill  <= KILL_RST;
            r_eof   <= EOF_RST;
            r_susp  <= SUSPEND_RST;
            r_fg    <= FG_RST;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_MODE:    r_mode  <= i_cfg.data[5:0];
                REG_INTR:    r_intr  <= i_cfg.data[7:0];
                REG_QUIT:    r_quit  <= i_cfg.data[7:0];
                REG_ERASE:   r_erase <= i_cfg.data[7:0];
                REG_KILL:    r_kill  <= i_cfg.data[7:0];
                REG_EOF:     r_eof   <= i_cfg.data[7:0];
                REG_SUSPEND: r_susp  <= i_cfg.data[7:0];
                REG_FG:      r_fg    <= i_cfg.data;
                default:     r_fg    <= r_fg;
            endcase
        end
    end

    // The character is held with CR already mapped to LF where asked
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_char <= (r_mode[MODE_ICRNL] && i_char == CH_CR) ? CH_LF : i_char;
        end
    end

    always_comb begin
        if (!r_mode[MODE_ENABLE]) begin
            kind = K_OFF;
        end else if (r_mode[MODE_SIG] && r_char == r_intr) begin
            kind = K_INTR;
        end else if (r_mode[MODE_SIG] && r_char == r_quit) begin
            kind = K_QUIT;
        end else if (r_mode[MODE_SIG] && r_char == r_susp) begin
            kind = K_SUSP;
        end else if (!r_mode[MODE_CANON]) begin
            kind = K_RAW;
        end else if (r_char == r_erase) begin
            kind = K_ERASE;
        end else if (r_char == r_kill) begin
            kind = K_KILL;
        end else if (r_char == r_eof) begin
            kind = K_EOF;
        end else begin
            kind = K_NORMAL;
        end
    end

    always_comb begin
        n_rd_pos = r_rd_pos;
        n_wr_pos = r_wr_pos;
        if (i_cmd.kill) begin
            n_rd_pos = '0;
            n_wr_pos = '0;
        end
        if (i_cmd.push) begin
            n_wr_pos = ptr_inc(r_wr_pos);
        end
        if (i_cmd.erase) begin
            n_wr_pos = ptr_dec(r_wr_pos);
        end
        if (i_cmd.pop) begin
            n_rd_pos = ptr_inc(r_rd_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pos <= '0;
            r_wr_pos <= '0;
        end else begin
            r_rd_pos <= n_rd_pos;
            r_wr_pos <= n_wr_pos;
        end
    end

    // The read port follows the next read pointer, so the head of the line
    // is ready in the next cycle; a write to that same entry is forwarded.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_line_store[r_wr_pos] <= r_char;
        end
        if (i_cmd.push && r_wr_pos == n_rd_pos) begin
            r_rd_data <= r_char;
        end else begin
            r_rd_data <= r_line_store[n_rd_pos];
        end
    end

    always_comb begin
        case (i_cmd.sel)
            SEL_SIG: begin
                case (kind)
                    K_QUIT:  emit_byte = SIG_QUIT;
                    K_SUSP:  emit_byte = SIG_SUSPEND;
                    default: emit_byte = SIG_INTR;
                endcase
            end
            SEL_CHAR:  emit_byte = r_char;
            SEL_FF:    emit_byte = CH_EOF_MARK;
            SEL_BS:    emit_byte = CH_BS;
            SEL_SP:    emit_byte = CH_SP;
            SEL_CR:    emit_byte = CH_CR;
            SEL_LF:    emit_byte = CH_LF;
            SEL_STORE: emit_byte = r_rd_data;
            default:   emit_byte = r_char;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_dest  <= i_cmd.dest;
            r_out_byte  <= emit_byte;
            r_out_group <= (i_cmd.dest == DEST_SIG) ? r_fg : '0;
            r_out_last  <= i_cmd.last;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.destination  = r_out_dest;
    assign o_res.data_byte    = r_out_byte;
    assign o_res.target_group = r_out_group;
    assign o_res.last         = r_out_last;

    assign o_status.kind     = kind;
    assign o_status.echo     = r_mode[MODE_ECHO];
    assign o_status.onlcr    = r_mode[MODE_ONLCR];
    assign o_status.is_lf    = (r_char == CH_LF);
    assign o_status.empty    = (r_rd_pos == r_wr_pos);
    assign o_status.full     = (ptr_inc(r_wr_pos) == r_rd_pos);
    assign o_status.pop_last = (ptr_inc(r_rd_pos) == r_wr_pos);
    assign o_status.out_free = !r_out_valid || o_res.ready;

endmodule

[rtl/tld_ctrl.sv]
// ============================================================================
// tld_ctrl
// Sequencer of the line discipline: takes one character, edits the line
// store and steps through the results that the character causes.
// ============================================================================
module tld_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tld_pkg::t_status  i_status,
    output tld_pkg::t_cmd     o_cmd
);
    import tld_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SIG,
        S_RAW,
        S_ECHO,
        S_ECHO_CR,
        S_ERASE_BS1,
        S_ERASE_SP,
        S_ERASE_BS2,
        S_KILL_CR,
        S_KILL_LF,
        S_EOF,
        S_FLUSH
    } t_state;

    t_state r_state, n_state;
    logic   fire;

    assign fire = i_status.out_free;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.dest = DEST_ECHO;
        o_cmd.sel  = SEL_CHAR;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                // No character is taken while reset is held
                o_in_ready  = i_rst_n;
                o_cmd.latch = i_in_valid && i_rst_n;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_status.kind)
                    K_INTR, K_QUIT, K_SUSP: n_state = S_SIG;
                    K_RAW:                  n_state = S_RAW;
                    K_EOF:                  n_state = S_EOF;
                    K_ERASE: begin
                        // Erasing an empty line does nothing at all
                        o_cmd.erase = !i_status.empty;
                        n_state = (!i_status.empty && i_status.echo) ?
                                  S_ERASE_BS1 : S_IDLE;
                    end
                    K_KILL: begin
                        o_cmd.kill = 1'b1;
                        n_state = i_status.echo ? S_KILL_CR : S_IDLE;
                    end
                    K_NORMAL: begin
                        // A full store drops the character, but echo and flush go on
                        o_cmd.push = !i_status.full;
                        if (i_status.echo) begin
                            n_state = (i_status.onlcr && i_status.is_lf) ?
                                      S_ECHO_CR : S_ECHO;
                        end else begin
                            n_state = i_status.is_lf ? S_FLUSH : S_IDLE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_SIG: begin
                o_cmd.emit = fire;
                o_cmd.dest = DEST_SIG;
                o_cmd.sel  = SEL_SIG;
                o_cmd.last = 1'b1;
                if (fire) begin
                    n_state = S_IDLE;
                end
            end
            S_RAW: begin
                o_cmd.emit = fire;
                o_cmd.dest = DEST_READ;
                o_cmd.sel  = SEL_CHAR;
                o_cmd.last = !i_status.echo;
                if (fire) begin
                    n_state = i_status.echo ? S_ECHO : S_IDLE;
                end
            end
            S_ECHO: begin
                // In canonical mode a newline is followed by the line flush
                o_cmd.emit = fire;
                o_cmd.sel  = SEL_CHAR;
                o_cmd.last = !(i_status.kind == K_NORMAL && i_status.is_lf);
                if (fire) begin
                    n_state = o_cmd.last ? S_IDLE : S_FLUSH;
                end
            end
            S_ECHO_CR: begin
                o_cmd.emit = fire;
                o_cmd.sel  = SEL_CR;
                if (fire) begin
                    n_state = S_ECHO;
                end
            end
            S_ERASE_BS1: begin
                o_cmd.emit = fire;
                o_cmd.sel  = SEL_BS;
                if (fire) begin
                    n_state = S_ERASE_SP;
                end
            end
            S_ERASE_SP: begin
                o_cmd.emit = fire;
                o_cmd.sel  = SEL_SP;
                if (fire) begin
                    n_state = S_ERASE_BS2;
                end
            end
            S_ERASE_BS2: begin
                o_cmd.emit = fire;
                o_cmd.sel  = SEL_BS;
                o_cmd.last = 1'b1;
                if (fire) begin
                    n_state = S_IDLE;
                end
            end
            S_KILL_CR: begin
                o_cmd.emit = fire;
                o_cmd.sel  = SEL_CR;
                if (fire) begin
                    n_state = S_KILL_LF;
                end
            end
            S_KILL_LF: begin
                o_cmd.emit = fire;
                o_cmd.sel  = SEL_LF;
                o_cmd.last = 1'b1;
                if (fire) begin
                    n_state = S_IDLE;
                end
            end
            S_EOF: begin
                o_cmd.emit = fire;
                o_cmd.dest = DEST_READ;
                o_cmd.sel  = SEL_FF;
                o_cmd.last = 1'b1;
                if (fire) begin
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                o_cmd.emit = fire;
                o_cmd.pop  = fire;
                o_cmd.dest = DEST_READ;
                o_cmd.sel  = SEL_STORE;
                o_cmd.last = i_status.pop_last;
                if (fire && i_status.pop_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/terminal_line_discipline_core.sv]
// ============================================================================
// terminal_line_discipline_core
// Receive side of a terminal line discipline with a canonical line editor.
// ============================================================================
// Characters arrive one beat at a time on i_char_ch; every result leaves as
// one beat on o_res_ch, and the last result of a character carries last = 1.
// Some characters (disabled mode, erase on an empty line, edits with echo
// off) cause no result at all. Registers are written on i_cfg_ch, which only
// stalls during reset; write them only while no character is in progress.
// A character is latched in the idle state and decoded in the next cycle;
// its results then follow one beat per cycle while the receiver keeps up, a
// pace set by the single result register and by the line store, whose
// registered read port streams one entry per cycle. When the receiver stalls
// the current result holds and the sequence waits; no new character is taken
// until the last result of the current one has been loaded into the result
// register.
// Reset loads the register defaults and empties the line; the store contents
// themselves are not cleared, as only entries between the pointers are read.
// ============================================================================
module terminal_line_discipline_core #(
    parameter int LINE_DEPTH = tld_pkg::LINE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tld_char_if.sink   i_char_ch,
    tld_cfg_if.sink    i_cfg_ch,
    tld_res_if.source  o_res_ch
);
    import tld_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    assign i_char_ch.ready = in_ready;

    tld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_char_ch.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tld_datapath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg_ch),
        .i_char   (i_char_ch.char_in),
        .o_res    (o_res_ch),
        .i_cmd    (cmd),
        .o_status (status)
    );

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the terminal line discipline receive path.
// Characters go in on the character channel with random gaps. Every one that
// is accepted is run through a line editor model kept in a small scoreboard,
// which queues the echo, reader and signal beats that it should cause. Each
// result beat is checked field by field against the oldest queued beat.
// Registers are rewritten between phases once the core has gone quiet.
// ============================================================================
module tb;
    import tld_pkg::*;

    localparam int DEPTH        = LINE_DEPTH_DEF;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 8;

    typedef struct {
        t_dest  dest;
        t_byte  data;
        t_group group;
        logic   last;
    } t_beat;

    // Line editor model and the queue of beats it expects.
    class line_discipline_scoreboard;
        t_mode  mode;
        t_byte  intr_ch, quit_ch, erase_ch, kill_ch, eof_ch, susp_ch;
        t_group fg;
        t_byte  line_buf [DEPTH];
        int     rd_pos, wr_pos;
        t_beat  expected_beats [$];
        int     errors, chars_seen, beats_seen;

        function new();
            mode     = MODE_RST;
            intr_ch  = INTR_RST;
            quit_ch  = QUIT_RST;
            erase_ch = ERASE_RST;
            kill_ch  = KILL_RST;
            eof_ch   = EOF_RST;
            susp_ch  = SUSPEND_RST;
            fg       = FG_RST;
            rd_pos   = 0;
            wr_pos   = 0;
        endfunction

        function void write_reg(t_reg_idx idx, t_group val);
            case (idx)
                REG_MODE:    mode     = val[5:0];
                REG_INTR:    intr_ch  = val[7:0];
                REG_QUIT:    quit_ch  = val[7:0];
                REG_ERASE:   erase_ch = val[7:0];
                REG_KILL:    kill_ch  = val[7:0];
                REG_EOF:     eof_ch   = val[7:0];
                REG_SUSPEND: susp_ch  = val[7:0];
                REG_FG:      fg       = val;
                default: ;
            endcase
        endfunction

        function void add_beat(t_dest d, t_byte b, t_group g);
            t_beat bt;
            bt.dest  = d;
            bt.data  = b;
            bt.group = g;
            bt.last  = 1'b0;
            expected_beats.push_back(bt);
        endfunction

        function void note_char(t_byte c_in);
            t_byte c;
            int    first;
            logic  echo_on;
            c       = c_in;
            first   = expected_beats.size();
            echo_on = mode[MODE_ECHO];
            chars_seen++;
            if (!mode[MODE_ENABLE])
                return;
            if (mode[MODE_ICRNL] && c == CH_CR)
                c = CH_LF;
            // Signal characters take precedence over the editing characters.
            if (mode[MODE_SIG] && c == intr_ch) begin
                add_beat(DEST_SIG, SIG_INTR, fg);
            end else if (mode[MODE_SIG] && c == quit_ch) begin
                add_beat(DEST_SIG, SIG_QUIT, fg);
            end else if (mode[MODE_SIG] && c == susp_ch) begin
                add_beat(DEST_SIG, SIG_SUSPEND, fg);
            end else if (!mode[MODE_CANON]) begin
                add_beat(DEST_READ, c, '0);
                if (echo_on)
                    add_beat(DEST_ECHO, c, '0);
            end else if (c == erase_ch) begin
                if (wr_pos != rd_pos) begin
                    wr_pos = (wr_pos + DEPTH - 1) % DEPTH;
                    if (echo_on) begin
                        add_beat(DEST_ECHO, CH_BS, '0);
                        add_beat(DEST_ECHO, CH_SP, '0);
                        add_beat(DEST_ECHO, CH_BS, '0);
                    end
                end
            end else if (c == kill_ch) begin
                rd_pos = 0;
                wr_pos = 0;
                if (echo_on) begin
                    add_beat(DEST_ECHO, CH_CR, '0);
                    add_beat(DEST_ECHO, CH_LF, '0);
                end
            end else if (c == eof_ch) begin
                add_beat(DEST_READ, CH_EOF_MARK, '0);
            end else begin
                // A full ring drops the character but still echoes and flushes.
                if ((wr_pos + 1) % DEPTH != rd_pos) begin
                    line_buf[wr_pos] = c;
                    wr_pos = (wr_pos + 1) % DEPTH;
                end
                if (echo_on) begin
                    if (mode[MODE_ONLCR] && c == CH_LF)
                        add_beat(DEST_ECHO, CH_CR, '0);
                    add_beat(DEST_ECHO, c, '0);
                end
                if (c == CH_LF) begin
                    while (rd_pos != wr_pos) begin
                        add_beat(DEST_READ, line_buf[rd_pos], '0);
                        rd_pos = (rd_pos + 1) % DEPTH;
                    end
                end
            end
            if (expected_beats.size() > first)
                expected_beats[expected_beats.size() - 1].last = 1'b1;
        endfunction

        function void check_beat(logic [1:0] d, t_byte b, t_group g, logic l);
            t_beat exp_b;
            beats_seen++;
            if (expected_beats.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat dest %0d byte %02h group %04h last %0b",
                         $time, d, b, g, l);
                return;
            end
            exp_b = expected_beats.pop_front();
            if (d !== exp_b.dest) begin
                errors++;
                $display("%0t: destination expected %0d actual %0d", $time, exp_b.dest, d);
            end
            if (b !== exp_b.data) begin
                errors++;
                $display("%0t: data byte expected %02h actual %02h", $time, exp_b.data, b);
            end
            if (g !== exp_b.group) begin
                errors++;
                $display("%0t: target group expected %04h actual %04h", $time, exp_b.group, g);
            end
            if (l !== exp_b.last) begin
                errors++;
                $display("%0t: last expected %0b actual %0b", $time, exp_b.last, l);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    tld_char_if char_ch ();
    tld_cfg_if  cfg_ch ();
    tld_res_if  res_ch ();

    terminal_line_discipline_core i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_char_ch (char_ch),
        .i_cfg_ch  (cfg_ch),
        .o_res_ch  (res_ch)
    );

    line_discipline_scoreboard sb = new();

    t_group cfg_next [8];
    bit     no_idle      = 1'b0;
    bit     hold_off_req = 1'b0;
    int     cycle_count  = 0;
    int     settings_used = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Every accepted result beat is checked as it leaves the core.
    always @(posedge i_clk) begin
        if (res_ch.valid && res_ch.ready)
            sb.check_beat(res_ch.destination, res_ch.data_byte, res_ch.target_group,
                          res_ch.last);
    end

    // Receiver: random stall bursts, one long hold-off on request, none at the end.
    initial begin
        forever begin
            if (hold_off_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    function automatic int pick_gap();
        if (no_idle || $urandom_range(0, 4) != 0)
            return 0;
        return $urandom_range(1, 18);
    endfunction

    // Mostly printable text, with control characters of the current setting mixed in.
    function automatic t_byte pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 14) begin
            case ($urandom_range(0, 5))
                0: return sb.intr_ch;
                1: return sb.quit_ch;
                2: return sb.susp_ch;
                3: return sb.erase_ch;
                4: return sb.kill_ch;
                default: return sb.eof_ch;
            endcase
        end
        if (r < 22)
            return t_byte'($urandom_range(0, 31));
        if (r < 75)
            return t_byte'($urandom_range(8'h20, 8'h7E));
        return t_byte'($urandom_range(0, 255));
    endfunction

    task automatic send_char(input t_byte c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            char_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_ch.valid   <= 1'b1;
        char_ch.char_in <= c;
        @(posedge i_clk);
        while (!char_ch.ready) @(posedge i_clk);
        sb.note_char(c);
    endtask

    // Lines of random length and content, ended by LF or CR; now and then a
    // long one that runs into the full ring.
    task automatic send_lines(input int n);
        int left;
        left = $urandom_range(0, 10);
        for (int i = 0; i < n; i++) begin
            if (left == 0) begin
                send_char($urandom_range(0, 1) ? CH_LF : CH_CR);
                left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(0, 10);
            end else begin
                send_char(pick_char());
                left--;
            end
        end
    endtask

    task automatic wait_idle();
        char_ch.valid <= 1'b0;
        while (sb.expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic default_cfg();
        cfg_next[REG_MODE]    = t_group'(MODE_RST);
        cfg_next[REG_INTR]    = t_group'(INTR_RST);
        cfg_next[REG_QUIT]    = t_group'(QUIT_RST);
        cfg_next[REG_ERASE]   = t_group'(ERASE_RST);
        cfg_next[REG_KILL]    = t_group'(KILL_RST);
        cfg_next[REG_EOF]     = t_group'(EOF_RST);
        cfg_next[REG_SUSPEND] = t_group'(SUSPEND_RST);
        cfg_next[REG_FG]      = FG_RST;
    endtask

    task automatic fill_cfg(input t_byte ch, input t_group grp, input t_mode m);
        for (int i = int'(REG_INTR); i <= int'(REG_SUSPEND); i++)
            cfg_next[i] = t_group'(ch);
        cfg_next[REG_MODE] = t_group'(m);
        cfg_next[REG_FG]   = grp;
    endtask

    // Writes all registers back to back; unused upper data bits carry noise.
    task automatic configure();
        t_group mask;
        t_group val;
        for (int i = int'(REG_MODE); i <= int'(REG_FG); i++) begin
            mask = (i == int'(REG_MODE)) ? 16'h003F : (i == int'(REG_FG)) ? 16'hFFFF : 16'h00FF;
            val  = (t_group'($urandom) & ~mask) | (cfg_next[i] & mask);
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= 3'(i);
            cfg_ch.data  <= val;
            @(posedge i_clk);
            while (!cfg_ch.ready) @(posedge i_clk);
            sb.write_reg(t_reg_idx'(i), val);
        end
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    initial begin
        t_byte directed [$];
        t_mode m;

        i_rst_n         <= 1'b0;
        char_ch.valid   <= 1'b0;
        char_ch.char_in <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= REG_MODE;
        cfg_ch.data     <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting: edits, erase on an empty line, kill, end of file, the
        // three signals, byte extremes and a CR turned into a line flush.
        directed = '{8'h61, ERASE_RST, ERASE_RST, 8'h78, KILL_RST, EOF_RST, INTR_RST,
                     QUIT_RST, SUSPEND_RST, 8'h00, 8'hFF, 8'h80, CH_CR, CH_LF};
        foreach (directed[i])
            send_char(directed[i]);
        wait_idle();

        // Signal characters that coincide with the editing characters.
        default_cfg();
        cfg_next[REG_INTR]    = t_group'(ERASE_RST);
        cfg_next[REG_QUIT]    = t_group'(KILL_RST);
        cfg_next[REG_SUSPEND] = t_group'(EOF_RST);
        cfg_next[REG_FG]      = 16'hFFFF;
        configure();
        directed = '{8'h71, ERASE_RST, KILL_RST, EOF_RST};
        foreach (directed[i])
            send_char(directed[i]);
        wait_idle();

        // Same characters with signals off; CR stays CR without icrnl.
        cfg_next[REG_MODE] = 16'h0017;
        configure();
        directed = '{8'h71, ERASE_RST, 8'h7A, KILL_RST, EOF_RST, CH_CR, CH_LF};
        foreach (directed[i])
            send_char(directed[i]);
        wait_idle();

        // Disabled: nothing comes out and the line is left alone.
        fill_cfg(8'h03, 16'h0000, 6'h00);
        configure();
        send_lines(6);
        wait_idle();
        cfg_next[REG_MODE] = 16'h003E;
        configure();
        send_lines(6);
        wait_idle();

        // Random settings, raw and canonical.
        for (int ph = 0; ph < 4; ph++) begin
            m = t_mode'($urandom_range(0, 63));
            m[MODE_ENABLE] = 1'b1;
            if (ph == 0) m[MODE_CANON] = 1'b1;
            if (ph == 1) m[MODE_CANON] = 1'b0;
            for (int i = int'(REG_INTR); i <= int'(REG_SUSPEND); i++)
                cfg_next[i] = t_group'($urandom_range(0, 40));
            cfg_next[REG_MODE] = t_group'(m);
            cfg_next[REG_FG]   = t_group'($urandom);
            configure();
            send_lines(18);
            wait_idle();
        end

        // Extreme register values: all control characters equal.
        fill_cfg(8'h00, 16'h0000, 6'h3F);
        configure();
        send_lines(6);
        wait_idle();
        fill_cfg(8'hFF, 16'hFFFF, 6'h3F);
        configure();
        send_lines(6);
        wait_idle();

        // The receiver holds off while a long line is typed without gaps, so
        // the core backs up and the ring overflows before the flush.
        default_cfg();
        cfg_next[REG_FG] = t_group'($urandom);
        configure();
        hold_off_req = 1'b1;
        for (int i = 0; i < 36; i++) begin
            char_ch.valid   <= 1'b1;
            char_ch.char_in <= t_byte'($urandom_range(8'h20, 8'h7E));
            @(posedge i_clk);
            while (!char_ch.ready) @(posedge i_clk);
            sb.note_char(char_ch.char_in);
        end
        send_char(CH_LF);
        wait_idle();

        // Closing stretch at full rate on both sides.
        no_idle = 1'b1;
        cfg_next[REG_MODE] = t_group'(MODE_RST);
        configure();
        send_lines(30);
        wait_idle();
        repeat (40) @(posedge i_clk);

        $display("Sent %0d characters over %0d register settings, checked %0d result beats",
                 sb.chars_seen, settings_used, sb.beats_seen);
        $display("Covered raw and canonical modes, signals, editing, overflow and back-pressure");
        if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
